// ===== hw/rtl/bitmap_first_free_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// bitmap first free allocator assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef BITMAP_FIRST_FREE_ALLOCATOR_UNIT_ASSERT_SVH
`define BITMAP_FIRST_FREE_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BFFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
else $error("bffa assertion failed");
`define BFFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
else $error("bffa assertion failed");
`else
`define BFFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BFFA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bffa_pkg.sv =====
// ----------------------------------------------------------------------------
// bffa_pkg
// constants, command and status codes and shared types of the allocator
// ----------------------------------------------------------------------------
package bffa_pkg;

	localparam int GROUPS          = 4;
	localparam int WORDS_PER_GROUP = 256;
	localparam int WORD_BITS       = 32;

	localparam int GROUP_W  = $clog2(GROUPS);
	localparam int WIDX_W   = $clog2(WORDS_PER_GROUP);
	localparam int BIT_W    = $clog2(WORD_BITS);
	localparam int ADDR_W   = GROUP_W + WIDX_W;
	localparam int POS_W    = WIDX_W + BIT_W;
	localparam int BITS_CAP = WORDS_PER_GROUP * WORD_BITS;
	localparam int LIMIT_W  = $clog2(BITS_CAP + 1);
	localparam int CMP_W    = POS_W + 1;

	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = 14;
	localparam int ENTRY_W  = 15;
	localparam int GCNT_W   = 3;
	localparam int ITEM_WIDX_W = 8;
	localparam int ITEM_WORD_W = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_GROUP_COUNT    = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_GROUP = 1'd1;

	localparam logic [GCNT_W-1:0] GROUP_COUNT_RST    = 3'd1;
	localparam logic [CNT_W-1:0]  BITS_PER_GROUP_RST = 14'd8192;

	localparam logic [CMD_W-1:0] CMD_LOAD_WORD  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_COUNT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ALLOC      = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [GROUP_W-1:0] group;
		logic [LIMIT_W-1:0] limit;
	} scan_req_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [POS_W-1:0] pos;
	} scan_rsp_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    addr;
		logic [WORD_BITS-1:0] data;
	} word_wr_t;

endpackage

// ===== hw/rtl/bffa_if.sv =====
// ----------------------------------------------------------------------------
// bffa channel interfaces
// valid/ready channels for command items and result items
// ----------------------------------------------------------------------------
interface bffa_item_if;
	logic                               valid;
	logic                               ready;
	logic [bffa_pkg::CMD_W-1:0]         cmd;
	logic [bffa_pkg::GROUP_W-1:0]       group;
	logic [bffa_pkg::ITEM_WIDX_W-1:0]   word_index;
	logic [bffa_pkg::ITEM_WORD_W-1:0]   word_value;
	logic [bffa_pkg::CNT_W-1:0]         count_value;

	modport source (output valid, cmd, group, word_index, word_value, count_value,
		input ready);
	modport sink (input valid, cmd, group, word_index, word_value, count_value,
		output ready);
endinterface

interface bffa_result_if;
	logic                            valid;
	logic                            ready;
	logic [bffa_pkg::STATUS_W-1:0]   status;
	logic [bffa_pkg::ENTRY_W-1:0]    entry_number;
	logic [bffa_pkg::CNT_W-1:0]      free_left;

	modport source (output valid, status, entry_number, free_left, input ready);
	modport sink (input valid, status, entry_number, free_left, output ready);
endinterface

// ===== hw/rtl/bffa_ffz.sv =====
// ----------------------------------------------------------------------------
// bffa_ffz
// lowest clear bit finder over one bitmap word
// ----------------------------------------------------------------------------
module bffa_ffz (
	input  logic [bffa_pkg::WORD_BITS-1:0] word,
	output logic                           found,
	output logic [bffa_pkg::BIT_W-1:0]     idx
);

	always_comb begin
		found = 1'b0;
		idx   = '0;
		for (int i = bffa_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (!word[i]) begin
				found = 1'b1;
				idx   = bffa_pkg::BIT_W'(i);
			end
		end
	end

endmodule

// ===== hw/rtl/bffa_engine.sv =====
// ----------------------------------------------------------------------------
// bffa_engine
// bitmap memory and word scan sequencer, one word read and checked per cycle
// ----------------------------------------------------------------------------
`include "bitmap_first_free_allocator_unit_assert.svh"

module bffa_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  bffa_pkg::scan_req_t req,
	input  bffa_pkg::word_wr_t  ld,
	input  logic                ack,
	output bffa_pkg::scan_rsp_t rsp
);

	localparam logic [1:0] E_IDLE = 2'd0;
	localparam logic [1:0] E_SCAN = 2'd1;
	localparam logic [1:0] E_DONE = 2'd2;

	localparam int RD_W = bffa_pkg::WIDX_W + 1;

	logic [bffa_pkg::WORD_BITS-1:0] mem_q [bffa_pkg::GROUPS * bffa_pkg::WORDS_PER_GROUP];

	logic [1:0]                       state_q;
	logic                             data_vld_s1;
	logic                             found_q;
	logic [RD_W-1:0]                  rd_idx_q;
	logic [bffa_pkg::GROUP_W-1:0]     grp_q;
	logic [bffa_pkg::LIMIT_W-1:0]     limit_q;
	logic [bffa_pkg::POS_W-1:0]       pos_q;
	logic [bffa_pkg::WIDX_W-1:0]      chk_idx_s1;
	logic [bffa_pkg::WORD_BITS-1:0]   rdata_s1;

	logic [bffa_pkg::CMP_W-1:0]       base_rd;
	logic [bffa_pkg::CMP_W-1:0]       base_chk;
	logic [bffa_pkg::CMP_W-1:0]       rem_chk;
	logic [bffa_pkg::WORD_BITS-1:0]   vmask;
	logic [bffa_pkg::WORD_BITS-1:0]   chk_word;
	logic                             ffz_found;
	logic [bffa_pkg::BIT_W-1:0]       ffz_idx;
	logic                             more;
	logic                             hit;
	logic                             rd_issue;
	logic [bffa_pkg::ADDR_W-1:0]      rd_addr;
	logic                             wr_en;
	logic [bffa_pkg::ADDR_W-1:0]      wr_addr;
	logic [bffa_pkg::WORD_BITS-1:0]   wr_data;

	assign base_rd  = bffa_pkg::CMP_W'({rd_idx_q, {bffa_pkg::BIT_W{1'b0}}});
	assign base_chk = bffa_pkg::CMP_W'({chk_idx_s1, {bffa_pkg::BIT_W{1'b0}}});
	assign rem_chk  = bffa_pkg::CMP_W'(limit_q) - base_chk;

	// bits at or past the limit count as used
	always_comb begin
		for (int i = 0; i < bffa_pkg::WORD_BITS; i++) begin
			vmask[i] = rem_chk > bffa_pkg::CMP_W'(i);
		end
	end

	assign chk_word = rdata_s1 | ~vmask;

	bffa_ffz u_ffz (
		.word  (chk_word),
		.found (ffz_found),
		.idx   (ffz_idx)
	);

	assign more = (rd_idx_q < RD_W'(bffa_pkg::WORDS_PER_GROUP))
		&& (base_rd < bffa_pkg::CMP_W'(limit_q));
	assign hit      = data_vld_s1 && ffz_found;
	assign rd_issue = (state_q == E_SCAN) && more && !hit;
	assign rd_addr  = {grp_q, rd_idx_q[bffa_pkg::WIDX_W-1:0]};

	// set-bit write back shares the port with word loads
	assign wr_en   = ld.we || hit;
	assign wr_addr = hit ? {grp_q, chk_idx_s1} : ld.addr;
	assign wr_data = hit ? (rdata_s1 | (bffa_pkg::WORD_BITS'(1) << ffz_idx)) : ld.data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_issue) begin
			rdata_s1   <= mem_q[rd_addr];
			chk_idx_s1 <= rd_idx_q[bffa_pkg::WIDX_W-1:0];
		end
		if (start) begin
			grp_q   <= req.group;
			limit_q <= req.limit;
		end
		if (hit) begin
			pos_q <= {chk_idx_s1, ffz_idx};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= E_IDLE;
			data_vld_s1 <= 1'b0;
			found_q     <= 1'b0;
			rd_idx_q    <= '0;
		end else begin
			data_vld_s1 <= rd_issue;
			if (rd_issue) begin
				rd_idx_q <= rd_idx_q + RD_W'(1);
			end
			case (state_q)
				E_IDLE: begin
					if (start) begin
						rd_idx_q <= '0;
						found_q  <= 1'b0;
						state_q  <= (req.limit == '0) ? E_DONE : E_SCAN;
					end
				end
				E_SCAN: begin
					if (hit) begin
						found_q <= 1'b1;
						state_q <= E_DONE;
					end else if (!more) begin
						state_q <= E_DONE;
					end
				end
				E_DONE: begin
					if (ack) begin
						state_q <= E_IDLE;
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	assign rsp.done  = (state_q == E_DONE);
	assign rsp.found = found_q;
	assign rsp.pos   = pos_q;

	`BFFA_ASSERT_IMP(a_vld_in_scan, clk, arst_n, data_vld_s1, state_q == E_SCAN)
	`BFFA_ASSERT_IMP(a_start_idle, clk, arst_n, start, state_q == E_IDLE)
	`BFFA_ASSERT_NXT(a_hit_done, clk, arst_n, hit, state_q == E_DONE && found_q)
	`BFFA_ASSERT_IMP(a_pos_in_limit, clk, arst_n, rsp.done && rsp.found,
		bffa_pkg::CMP_W'(pos_q) < bffa_pkg::CMP_W'(limit_q))

endmodule

// ===== hw/rtl/bitmap_first_free_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// bitmap_first_free_allocator_unit
// first fit allocator over per-group bitmaps with per-group free counts
// ----------------------------------------------------------------------------
// Commands arrive on the item channel and each gives exactly one transfer on
// the result channel. cfg_we/cfg_index/cfg_data write group_count (index 0)
// and bits_per_group (index 1); write them only while the block is idle.
// Word loads, count loads, rejected allocations and the unused command code
// produce their result without a scan, through the output register.
// An allocation reads one bitmap word per cycle from the bitmap memory and
// checks it in the first-clear-bit finder. It reads the words up to and
// including the one that holds the free bit, or every word below the limit
// when the group is full, so at most ceil(min(bits_per_group, 8192) / 32)
// words. With bits_per_group at zero no word is read.
// One item is in work at a time; item.ready drops from the transfer until
// the result moves to the output register.
// Reset clears the free counts and the control state, sets group_count to 1
// and bits_per_group to 8192. Bitmap words hold nothing defined until loaded
// and must be loaded before a scan reaches them. No clearing pass is needed.
// If the receiver stalls, the output register holds its result and one more
// item is accepted and finished; it then waits until the register frees.
// ----------------------------------------------------------------------------
`include "bitmap_first_free_allocator_unit_assert.svh"

module bitmap_first_free_allocator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [bffa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bffa_pkg::CFG_DATA_W-1:0]     cfg_data,
	bffa_item_if.sink                           item,
	bffa_result_if.source                       result
);

	logic [bffa_pkg::GCNT_W-1:0]    gcnt_q;
	logic [bffa_pkg::CNT_W-1:0]     bpg_q;
	logic [bffa_pkg::CNT_W-1:0]     free_cnt_q [bffa_pkg::GROUPS];

	logic                           busy_q;
	logic                           scan_q;
	logic                           range_q;
	logic [bffa_pkg::GROUP_W-1:0]   item_group_q;
	logic [bffa_pkg::ENTRY_W-1:0]   prod_q;

	logic                           out_valid_q;
	logic [bffa_pkg::STATUS_W-1:0]  out_status_q;
	logic [bffa_pkg::ENTRY_W-1:0]   out_entry_q;
	logic [bffa_pkg::CNT_W-1:0]     out_free_q;

	logic                           item_acc;
	logic                           is_alloc;
	logic                           in_range;
	logic                           scan_start;
	logic [bffa_pkg::ENTRY_W:0]     prod_full;
	logic [bffa_pkg::LIMIT_W-1:0]   limit;
	logic                           res_ready;
	logic                           move;
	logic                           alloc_ok;
	logic [bffa_pkg::CNT_W-1:0]     cur_cnt;
	logic [bffa_pkg::CNT_W-1:0]     dec_cnt;
	logic [bffa_pkg::STATUS_W-1:0]  res_status;
	logic [bffa_pkg::ENTRY_W-1:0]   res_entry;
	logic [bffa_pkg::CNT_W-1:0]     res_free;

	bffa_pkg::scan_req_t            eng_req;
	bffa_pkg::scan_rsp_t            eng_rsp;
	bffa_pkg::word_wr_t             eng_ld;

	assign item.ready = !busy_q;
	assign item_acc   = item.valid && item.ready;
	assign is_alloc   = (item.cmd == bffa_pkg::CMD_ALLOC);
	assign in_range   = bffa_pkg::GCNT_W'(item.group) < gcnt_q;
	assign scan_start = item_acc && is_alloc && in_range;

	assign prod_full = (bffa_pkg::ENTRY_W + 1)'(item.group)
		* (bffa_pkg::ENTRY_W + 1)'(bpg_q);
	assign limit = (bpg_q > bffa_pkg::CNT_W'(bffa_pkg::BITS_CAP))
		? bffa_pkg::LIMIT_W'(bffa_pkg::BITS_CAP) : bffa_pkg::LIMIT_W'(bpg_q);

	assign eng_req.group = item.group;
	assign eng_req.limit = limit;
	assign eng_ld.we     = item_acc && (item.cmd == bffa_pkg::CMD_LOAD_WORD);
	assign eng_ld.addr   = {item.group, item.word_index[bffa_pkg::WIDX_W-1:0]};
	assign eng_ld.data   = item.word_value[bffa_pkg::WORD_BITS-1:0];

	bffa_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.req    (eng_req),
		.ld     (eng_ld),
		.ack    (move),
		.rsp    (eng_rsp)
	);

	assign res_ready = busy_q && (!scan_q || eng_rsp.done);
	assign move      = res_ready && (!out_valid_q || result.ready);
	assign alloc_ok  = scan_q && eng_rsp.found;
	assign cur_cnt   = free_cnt_q[item_group_q];
	assign dec_cnt   = (cur_cnt == '0) ? '0 : cur_cnt - bffa_pkg::CNT_W'(1);

	always_comb begin
		if (range_q) begin
			res_status = bffa_pkg::ST_RANGE;
		end else if (scan_q && !eng_rsp.found) begin
			res_status = bffa_pkg::ST_FULL;
		end else begin
			res_status = bffa_pkg::ST_DONE;
		end
	end

	assign res_entry = alloc_ok ? (prod_q + bffa_pkg::ENTRY_W'(eng_rsp.pos)) : '0;
	assign res_free  = alloc_ok ? dec_cnt : cur_cnt;

	always_ff @(posedge clk) begin
		if (item_acc) begin
			item_group_q <= item.group;
			prod_q       <= prod_full[bffa_pkg::ENTRY_W-1:0];
		end
		if (move) begin
			out_status_q <= res_status;
			out_entry_q  <= res_entry;
			out_free_q   <= res_free;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gcnt_q      <= bffa_pkg::GROUP_COUNT_RST;
			bpg_q       <= bffa_pkg::BITS_PER_GROUP_RST;
			busy_q      <= 1'b0;
			scan_q      <= 1'b0;
			range_q     <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < bffa_pkg::GROUPS; i++) begin
				free_cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					bffa_pkg::CFG_GROUP_COUNT: begin
						gcnt_q <= cfg_data[bffa_pkg::GCNT_W-1:0];
					end
					bffa_pkg::CFG_BITS_PER_GROUP: begin
						bpg_q <= cfg_data[bffa_pkg::CNT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (item_acc) begin
				busy_q  <= 1'b1;
				scan_q  <= is_alloc && in_range;
				range_q <= is_alloc && !in_range;
				if (item.cmd == bffa_pkg::CMD_LOAD_COUNT) begin
					free_cnt_q[item.group] <= item.count_value;
				end
			end
			if (move) begin
				busy_q      <= 1'b0;
				scan_q      <= 1'b0;
				range_q     <= 1'b0;
				out_valid_q <= 1'b1;
				if (alloc_ok) begin
					free_cnt_q[item_group_q] <= dec_cnt;
				end
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid        = out_valid_q;
	assign result.status       = out_status_q;
	assign result.entry_number = out_entry_q;
	assign result.free_left    = out_free_q;

	`BFFA_ASSERT_NXT(a_acc_busy, clk, arst_n, item_acc, busy_q)
	`BFFA_ASSERT_IMP(a_done_scan, clk, arst_n, eng_rsp.done, busy_q && scan_q)
	`BFFA_ASSERT_IMP(a_full_zero, clk, arst_n,
		out_valid_q && out_status_q == bffa_pkg::ST_FULL, out_entry_q == '0)

endmodule
